// ----- src/frxc_pkg.sv -----
// frxc_pkg: shared types and constants for the XOR-checksum frame receiver.
// No dependencies; used by frame_receiver_xor_checksum, frxc_cmp and frxc_checker.
package frxc_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam int CMP_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// input beat modes
	localparam logic [1:0] MODE_BYTE  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_GOOD    = 3'd0;
	localparam logic [2:0] ST_LENGTH  = 3'd1;
	localparam logic [2:0] ST_CSUM    = 3'd2;
	localparam logic [2:0] ST_BAD_END = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  frame_type;
		logic [6:0]  frame_length;
		logic [5:0]  byte_index;
		logic [7:0]  data_byte;
		logic        has_data;
		logic        last;
		logic [31:0] good_frames;
		logic [31:0] bad_frames;
	} out_item_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

// ----- src/frame_receiver_xor_checksum.sv -----
// frame_receiver_xor_checksum: start/type/length/payload/XOR/end deframer.
// Each beat is accepted in S_IDLE, then makes one pass through the shared compare unit.
// Errors post one result via S_EXEC then S_POST, which waits while the output stalls;
// a good frame posts its bytes in turn via S_RD (RAM read) and S_EMIT (load).
// arst_n clears control, counters and config (2, 3, 1000); payload RAM is not cleared.
module frame_receiver_xor_checksum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  frxc_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output frxc_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [frxc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [frxc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;  // one compare, update frame state
	localparam logic [2:0] S_POST = 3'd2;  // single result (error or empty frame)
	localparam logic [2:0] S_RD   = 3'd3;  // payload RAM read in flight
	localparam logic [2:0] S_EMIT = 3'd4;  // read data ready, load output register

	// frame phases
	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_TYPE = 3'd1;
	localparam logic [2:0] PH_LEN  = 3'd2;
	localparam logic [2:0] PH_DATA = 3'd3;
	localparam logic [2:0] PH_CSUM = 3'd4;
	localparam logic [2:0] PH_END  = 3'd5;

	localparam int IW = frxc_pkg::IDX_W;
	localparam int CW = frxc_pkg::CMP_W;

	logic [2:0]  state_q;
	logic [2:0]  phase_q;
	logic [7:0]  start_marker_q;
	logic [7:0]  end_marker_q;
	logic [15:0] timeout_q;

	frxc_pkg::in_item_t item_q;     // beat under work
	logic [7:0]  type_q;
	logic [6:0]  len_q;             // saturated at 127
	logic [6:0]  pcount_q;
	logic [7:0]  xor_q;
	logic [15:0] gap_q;
	logic [31:0] good_q;
	logic [31:0] bad_q;
	logic [2:0]  post_status_q;
	logic [IW-1:0] idx_q;           // payload walk pointer

	logic                out_valid_q;
	frxc_pkg::out_item_t out_q;

	// shared compare unit operands
	logic [CW-1:0]      cmp_a;
	logic [CW-1:0]      cmp_b;
	frxc_pkg::cmp_res_t cmp_res;

	logic       slot_free;
	logic [7:0] rd_data;
	logic       ram_we;
	logic [6:0] idx_next;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign slot_free = !out_valid_q || out_ready;
	assign idx_next  = {{(7 - IW){1'b0}}, idx_q} + 7'd1;

	// Operand select: each beat needs at most one compare.
	always_comb begin
		cmp_a = '0;
		cmp_b = '0;
		if (item_q.mode == frxc_pkg::MODE_TICK) begin
			cmp_a = {1'b0, gap_q} + 17'd1;
			cmp_b = {1'b0, timeout_q};
		end else begin
			unique case (phase_q)
				PH_HUNT: begin
					cmp_a = {9'd0, item_q.rx_byte};
					cmp_b = {9'd0, start_marker_q};
				end
				PH_LEN: begin
					cmp_a = {9'd0, item_q.rx_byte};
					cmp_b = CW'(frxc_pkg::MAX_PAYLOAD);
				end
				PH_DATA: begin
					cmp_a = {10'd0, pcount_q} + 17'd1;
					cmp_b = {10'd0, len_q};
				end
				PH_CSUM: begin
					cmp_a = {9'd0, item_q.rx_byte};
					cmp_b = {9'd0, xor_q};
				end
				PH_END: begin
					cmp_a = {9'd0, item_q.rx_byte};
					cmp_b = {9'd0, end_marker_q};
				end
				default: begin
					cmp_a = '0;
					cmp_b = '0;
				end
			endcase
		end
	end

	frxc_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// payload bytes go in as they arrive in the data phase
	assign ram_we = (state_q == S_EXEC) && (item_q.mode == frxc_pkg::MODE_BYTE)
		&& (phase_q == PH_DATA);

	frxc_ram #(
		.WIDTH (8),
		.DEPTH (frxc_pkg::MAX_PAYLOAD)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pcount_q[IW-1:0]),
		.wdata (item_q.rx_byte),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// input capture happens only in idle
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			phase_q        <= PH_HUNT;
			start_marker_q <= 8'd2;
			end_marker_q   <= 8'd3;
			timeout_q      <= 16'd1000;
			type_q         <= '0;
			len_q          <= '0;
			pcount_q       <= '0;
			xor_q          <= '0;
			gap_q          <= '0;
			good_q         <= '0;
			bad_q          <= '0;
			post_status_q  <= frxc_pkg::ST_GOOD;
			idx_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					frxc_pkg::REG_START_MARKER:  start_marker_q <= cfg_wdata[7:0];
					frxc_pkg::REG_END_MARKER:    end_marker_q   <= cfg_wdata[7:0];
					frxc_pkg::REG_TIMEOUT_TICKS: timeout_q      <= cfg_wdata;
					default: ;
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					unique case (item_q.mode)
						frxc_pkg::MODE_CLEAR: begin
							good_q <= '0;
							bad_q  <= '0;
						end
						frxc_pkg::MODE_TICK: begin
							if (phase_q != PH_HUNT) begin
								if (cmp_res.gt) begin
									bad_q         <= bad_q + 32'd1;
									phase_q       <= PH_HUNT;
									gap_q         <= '0;
									post_status_q <= frxc_pkg::ST_TIMEOUT;
									state_q       <= S_POST;
								end else begin
									gap_q <= gap_q + 16'd1;
								end
							end
						end
						frxc_pkg::MODE_BYTE: begin
							gap_q <= '0;
							unique case (phase_q)
								PH_HUNT: begin
									if (cmp_res.eq) begin
										phase_q  <= PH_TYPE;
										type_q   <= '0;
										len_q    <= '0;
										pcount_q <= '0;
										xor_q    <= '0;
									end
								end
								PH_TYPE: begin
									type_q  <= item_q.rx_byte;
									xor_q   <= xor_q ^ item_q.rx_byte;
									phase_q <= PH_LEN;
								end
								PH_LEN: begin
									len_q <= item_q.rx_byte[7] ? 7'd127 : item_q.rx_byte[6:0];
									xor_q <= xor_q ^ item_q.rx_byte;
									if (cmp_res.gt) begin
										bad_q         <= bad_q + 32'd1;
										phase_q       <= PH_HUNT;
										post_status_q <= frxc_pkg::ST_LENGTH;
										state_q       <= S_POST;
									end else begin
										pcount_q <= '0;
										phase_q  <= (item_q.rx_byte == 8'd0) ? PH_CSUM : PH_DATA;
									end
								end
								PH_DATA: begin
									xor_q    <= xor_q ^ item_q.rx_byte;
									pcount_q <= pcount_q + 7'd1;
									if (cmp_res.gt || cmp_res.eq) begin
										phase_q <= PH_CSUM;
									end
								end
								PH_CSUM: begin
									if (cmp_res.eq) begin
										phase_q <= PH_END;
									end else begin
										bad_q         <= bad_q + 32'd1;
										phase_q       <= PH_HUNT;
										post_status_q <= frxc_pkg::ST_CSUM;
										state_q       <= S_POST;
									end
								end
								PH_END: begin
									phase_q <= PH_HUNT;
									if (!cmp_res.eq) begin
										bad_q         <= bad_q + 32'd1;
										post_status_q <= frxc_pkg::ST_BAD_END;
										state_q       <= S_POST;
									end else begin
										good_q        <= good_q + 32'd1;
										post_status_q <= frxc_pkg::ST_GOOD;
										idx_q         <= '0;
										// empty payload still gives one result
										state_q       <= (len_q == 7'd0) ? S_POST : S_RD;
									end
								end
								default: phase_q <= PH_HUNT;
							endcase
						end
						default: ;
					endcase
				end
				S_POST: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (idx_next == len_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_next[IW-1:0];
							state_q <= S_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output payload register; loaded only with out_valid_q set alongside
	always_ff @(posedge clk) begin
		if (state_q == S_POST && slot_free) begin
			out_q.status       <= post_status_q;
			out_q.frame_type   <= type_q;
			out_q.frame_length <= len_q;
			out_q.byte_index   <= '0;
			out_q.data_byte    <= '0;
			out_q.has_data     <= 1'b0;
			out_q.last         <= 1'b1;
			out_q.good_frames  <= good_q;
			out_q.bad_frames   <= bad_q;
		end else if (state_q == S_EMIT && slot_free) begin
			out_q.status       <= frxc_pkg::ST_GOOD;
			out_q.frame_type   <= type_q;
			out_q.frame_length <= len_q;
			out_q.byte_index   <= 6'(idx_q);
			out_q.data_byte    <= rd_data;
			out_q.has_data     <= 1'b1;
			out_q.last         <= (idx_next == len_q);
			out_q.good_frames  <= good_q;
			out_q.bad_frames   <= bad_q;
		end
	end

endmodule

// ----- src/frxc_ram.sv -----
// frxc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module frxc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/frxc_cmp.sv -----
// frxc_cmp: shared magnitude/equality compare unit, time-shared by the sequencer.
// Depends on frxc_pkg.
module frxc_cmp (
	input  logic [frxc_pkg::CMP_W-1:0] a,
	input  logic [frxc_pkg::CMP_W-1:0] b,
	output frxc_pkg::cmp_res_t         res
);
	assign res.eq = (a == b);
	assign res.gt = (a > b);

endmodule

// ----- src/frxc_checker.sv -----
// frxc_checker: port-level assertions for the frame receiver, bound to the top.
// Depends on frxc_pkg and frame_receiver_xor_checksum.
module frxc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input frxc_pkg::out_item_t out_data
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one beat at a time: busy right after an accepted beat
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on back-to-back cycles");

	// error results are single, dataless beats
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != frxc_pkg::ST_GOOD |->
			out_data.last && !out_data.has_data)
		else $error("error result not a single dataless beat");

	// payload byte positions stay within the frame length
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.has_data |->
			({1'b0, out_data.byte_index} < out_data.frame_length))
		else $error("byte_index beyond frame_length");

endmodule

bind frame_receiver_xor_checksum frxc_checker u_frxc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
